### sv/gspch_pkg.sv
// Package for the gamepad SPI poll and configure host.
// Holds item types, codes, frame tables and the transmit byte function.
// No dependencies.
package gspch_pkg;

    localparam int POLL_FRAME_BYTES = 9;
    localparam int STORE_N = 8;
    localparam int MAX_FRAME = (POLL_FRAME_BYTES > 9) ? POLL_FRAME_BYTES : 9;
    localparam int IDX_W = $clog2(MAX_FRAME + 1);

    localparam logic [1:0] CMD_CONFIG = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_BYTE   = 2'd2;

    localparam logic [1:0] ACT_SEND = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    localparam logic [3:0] ERR_OK    = 4'd0;
    localparam logic [3:0] ERR_LINK  = 4'd1;
    localparam logic [3:0] ERR_SIG   = 4'd2;
    localparam logic [3:0] ERR_POLL1 = 4'd3;
    localparam logic [3:0] ERR_POLL2 = 4'd8;

    localparam logic [1:0] REG_ANALOG_LOCK = 2'd0;
    localparam logic [1:0] REG_RUMBLE      = 2'd1;
    localparam logic [1:0] REG_MAX_ATTEMPT = 2'd2;

    localparam logic [7:0] POLL_SIGNATURE = 8'h5A;
    localparam logic [7:0] ANALOG_ID      = 8'h73;
    localparam logic [7:0] POLL_CMD_BYTE  = 8'h42;
    localparam logic [7:0] HEADER_BYTE    = 8'h01;
    localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd5;
    localparam logic [7:0] STICK_CENTER   = 8'h80;

    localparam logic [7:0] ENTER_FRAME [9] =
        '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] ANALOG_FRAME [9] =
        '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] RUMBLE_FRAME [9] =
        '{8'h01, 8'h4D, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] EXIT_FRAME [9] =
        '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POLL1,
        PH_ENTER,
        PH_ANALOG,
        PH_RUMBLE,
        PH_EXIT,
        PH_POLL2,
        PH_READ
    } phase_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic       link_ok;
        logic       small_motor_on;
        logic [7:0] large_motor_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  link_action;
        logic [7:0]  tx_byte;
        logic        done_res;
        logic        success;
        logic [3:0]  error_code;
        logic [15:0] buttons_pressed;
        logic [7:0]  right_stick_x;
        logic [7:0]  right_stick_y;
        logic [7:0]  left_stick_x;
        logic [7:0]  left_stick_y;
        logic [7:0]  controller_id;
        logic        analog_mode;
    } res_item_t;

    typedef struct packed {
        logic      valid0;
        logic      valid1;
        res_item_t res0;
        res_item_t res1;
    } step_t;

    typedef struct packed {
        logic       analog_lock_enable;
        logic       rumble_enable;
        logic [3:0] max_attempts;
    } cfg_t;

    function automatic logic [IDX_W-1:0] frame_len(phase_t ph);
        logic [IDX_W-1:0] len;
        case (ph)
            PH_ENTER:  len = IDX_W'(5);
            PH_ANALOG: len = IDX_W'(9);
            PH_RUMBLE: len = IDX_W'(5);
            PH_EXIT:   len = IDX_W'(9);
            default:   len = IDX_W'(POLL_FRAME_BYTES);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] tx_at(phase_t ph, logic [IDX_W-1:0] i, logic [8:0] motor);
        logic [7:0] b;
        logic       in_tbl;
        in_tbl = (i < IDX_W'(9));
        case (ph)
            PH_ENTER:  b = in_tbl ? ENTER_FRAME[i[3:0]] : 8'h00;
            PH_ANALOG: b = in_tbl ? ANALOG_FRAME[i[3:0]] : 8'h00;
            PH_RUMBLE: b = in_tbl ? RUMBLE_FRAME[i[3:0]] : 8'h00;
            PH_EXIT:   b = in_tbl ? EXIT_FRAME[i[3:0]] : 8'h00;
            default:
            begin
                if (i == IDX_W'(0))
                    b = HEADER_BYTE;
                else if (i == IDX_W'(1))
                    b = POLL_CMD_BYTE;
                else if (i == IDX_W'(3))
                    b = {7'd0, motor[8]};
                else if (i == IDX_W'(4))
                    b = motor[7:0];
                else
                    b = 8'h00;
            end
        endcase
        return b;
    endfunction

endpackage

### sv/gspch_core.sv
// Sequencer of the gamepad host: frame phase, byte counter, retries and decode.
// Takes one registered item and gives up to two result items in the same cycle.
// Depends on gspch_pkg.
module gspch_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  gspch_pkg::in_item_t item,
    input  gspch_pkg::cfg_t     cfg,
    output gspch_pkg::step_t    step
);

    gspch_pkg::phase_t              phase_reg, phase_next;
    logic [gspch_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [3:0]                     attempt_reg, attempt_next;
    logic [8:0]                     motor_reg, motor_next;
    logic [15:0]                    buttons_reg, buttons_next;
    logic [7:0]                     sticks_reg [4];
    logic [7:0]                     sticks_next [4];
    logic [7:0]                     id_reg, id_next;
    logic                           analog_reg, analog_next;
    logic [7:0]                     store_reg [gspch_pkg::STORE_N];
    logic [7:0]                     store_next [gspch_pkg::STORE_N];
    logic [7:0]                     store_upd [gspch_pkg::STORE_N];

    always_comb
    begin
        logic                        do_fail;
        logic [3:0]                  fail_code;
        logic                        do_begin;
        logic                        begin_slot;
        gspch_pkg::phase_t           begin_ph;
        logic                        end_ok;
        logic [gspch_pkg::IDX_W-1:0] idx_inc;
        logic [3:0]                  limit;
        logic                        is_poll;

        do_fail    = 1'b0;
        fail_code  = gspch_pkg::ERR_OK;
        do_begin   = 1'b0;
        begin_slot = 1'b0;
        begin_ph   = gspch_pkg::PH_POLL1;
        end_ok     = 1'b0;
        idx_inc    = idx_reg + 1'b1;
        limit      = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
        is_poll    = (phase_reg == gspch_pkg::PH_POLL1) || (phase_reg == gspch_pkg::PH_POLL2)
                     || (phase_reg == gspch_pkg::PH_READ);

        phase_next   = phase_reg;
        idx_next     = idx_reg;
        attempt_next = attempt_reg;
        motor_next   = motor_reg;
        buttons_next = buttons_reg;
        id_next      = id_reg;
        analog_next  = analog_reg;
        for (int i = 0; i < 4; i++)
            sticks_next[i] = sticks_reg[i];
        for (int i = 0; i < gspch_pkg::STORE_N; i++)
        begin
            store_next[i] = store_reg[i];
            store_upd[i]  = (idx_reg == gspch_pkg::IDX_W'(i + 1)) ? item.rx_byte : store_reg[i];
        end

        step = '0;

        case (item.command)
            gspch_pkg::CMD_CONFIG:
            begin
                motor_next   = 9'd0;
                attempt_next = 4'd1;
                do_begin     = 1'b1;
                begin_ph     = gspch_pkg::PH_POLL1;
            end
            gspch_pkg::CMD_READ:
            begin
                motor_next = {item.small_motor_on, item.large_motor_level};
                do_begin   = 1'b1;
                begin_ph   = gspch_pkg::PH_READ;
            end
            gspch_pkg::CMD_BYTE:
            begin
                if (phase_reg != gspch_pkg::PH_IDLE)
                begin
                    if (!item.link_ok)
                    begin
                        do_fail   = 1'b1;
                        fail_code = gspch_pkg::ERR_LINK;
                    end
                    else
                    begin
                        for (int i = 0; i < gspch_pkg::STORE_N; i++)
                            store_next[i] = store_upd[i];
                        idx_next = idx_inc;
                        if (idx_inc < gspch_pkg::frame_len(phase_reg))
                        begin
                            step.valid0           = 1'b1;
                            step.res0.link_action = gspch_pkg::ACT_SEND;
                            step.res0.tx_byte     = gspch_pkg::tx_at(phase_reg, idx_inc, motor_reg);
                        end
                        else if (is_poll && store_upd[1] != gspch_pkg::POLL_SIGNATURE)
                        begin
                            do_fail = 1'b1;
                            if (phase_reg == gspch_pkg::PH_READ)
                                fail_code = gspch_pkg::ERR_SIG;
                            else if (phase_reg == gspch_pkg::PH_POLL1)
                                fail_code = gspch_pkg::ERR_POLL1;
                            else
                                fail_code = gspch_pkg::ERR_POLL2;
                        end
                        else
                        begin
                            case (phase_reg)
                                gspch_pkg::PH_POLL1:
                                begin
                                    do_begin = 1'b1;
                                    begin_ph = gspch_pkg::PH_ENTER;
                                end
                                gspch_pkg::PH_ENTER:
                                begin
                                    do_begin = 1'b1;
                                    if (cfg.analog_lock_enable)
                                        begin_ph = gspch_pkg::PH_ANALOG;
                                    else if (cfg.rumble_enable)
                                        begin_ph = gspch_pkg::PH_RUMBLE;
                                    else
                                        begin_ph = gspch_pkg::PH_EXIT;
                                end
                                gspch_pkg::PH_ANALOG:
                                begin
                                    do_begin = 1'b1;
                                    begin_ph = cfg.rumble_enable ? gspch_pkg::PH_RUMBLE
                                                                 : gspch_pkg::PH_EXIT;
                                end
                                gspch_pkg::PH_RUMBLE:
                                begin
                                    do_begin = 1'b1;
                                    begin_ph = gspch_pkg::PH_EXIT;
                                end
                                gspch_pkg::PH_EXIT:
                                begin
                                    do_begin = 1'b1;
                                    begin_ph = gspch_pkg::PH_POLL2;
                                end
                                default:
                                begin
                                    end_ok      = 1'b1;
                                    id_next     = store_upd[0];
                                    analog_next = (store_upd[0] == gspch_pkg::ANALOG_ID);
                                    if (phase_reg == gspch_pkg::PH_READ)
                                    begin
                                        buttons_next = ~{store_upd[3], store_upd[2]};
                                        for (int i = 0; i < 4; i++)
                                            sticks_next[i] = store_upd[i + 4];
                                    end
                                end
                            endcase
                            if (do_begin)
                            begin
                                step.valid0           = 1'b1;
                                step.res0.link_action = gspch_pkg::ACT_END;
                                begin_slot            = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (do_fail)
        begin
            step.valid0           = 1'b1;
            step.res0.link_action = gspch_pkg::ACT_END;
            if (phase_reg != gspch_pkg::PH_READ && attempt_reg < limit)
            begin
                attempt_next = attempt_reg + 4'd1;
                do_begin     = 1'b1;
                begin_slot   = 1'b1;
                begin_ph     = gspch_pkg::PH_POLL1;
            end
            else
            begin
                phase_next           = gspch_pkg::PH_IDLE;
                step.res0.done_res   = 1'b1;
                step.res0.error_code = fail_code;
            end
        end

        if (end_ok)
        begin
            phase_next            = gspch_pkg::PH_IDLE;
            step.valid0           = 1'b1;
            step.res0.link_action = gspch_pkg::ACT_END;
            step.res0.done_res    = 1'b1;
            step.res0.success     = 1'b1;
        end

        if (do_begin)
        begin
            phase_next = begin_ph;
            idx_next   = '0;
            for (int i = 0; i < gspch_pkg::STORE_N; i++)
                store_next[i] = 8'h00;
            if (begin_slot)
            begin
                step.valid1           = 1'b1;
                step.res1.link_action = gspch_pkg::ACT_SEND;
                step.res1.tx_byte     = gspch_pkg::tx_at(begin_ph, '0, motor_next);
            end
            else
            begin
                step.valid0           = 1'b1;
                step.res0.link_action = gspch_pkg::ACT_SEND;
                step.res0.tx_byte     = gspch_pkg::tx_at(begin_ph, '0, motor_next);
            end
        end

        step.res0.buttons_pressed = buttons_next;
        step.res0.right_stick_x   = sticks_next[0];
        step.res0.right_stick_y   = sticks_next[1];
        step.res0.left_stick_x    = sticks_next[2];
        step.res0.left_stick_y    = sticks_next[3];
        step.res0.controller_id   = id_next;
        step.res0.analog_mode     = analog_next;
        step.res1.buttons_pressed = buttons_next;
        step.res1.right_stick_x   = sticks_next[0];
        step.res1.right_stick_y   = sticks_next[1];
        step.res1.left_stick_x    = sticks_next[2];
        step.res1.left_stick_y    = sticks_next[3];
        step.res1.controller_id   = id_next;
        step.res1.analog_mode     = analog_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= gspch_pkg::PH_IDLE;
            idx_reg     <= '0;
            attempt_reg <= 4'd0;
            motor_reg   <= 9'd0;
            buttons_reg <= 16'd0;
            for (int i = 0; i < 4; i++)
                sticks_reg[i] <= gspch_pkg::STICK_CENTER;
            id_reg      <= 8'd0;
            analog_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            attempt_reg <= attempt_next;
            motor_reg   <= motor_next;
            buttons_reg <= buttons_next;
            for (int i = 0; i < 4; i++)
                sticks_reg[i] <= sticks_next[i];
            id_reg      <= id_next;
            analog_reg  <= analog_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < gspch_pkg::STORE_N; i++)
                store_reg[i] <= store_next[i];
        end
    end

endmodule

### sv/gspch_res_fifo.sv
// Four-entry result queue: takes up to two result items per cycle, gives one.
// Depends on gspch_pkg.
module gspch_res_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push0,
    input  logic                 push1,
    input  gspch_pkg::res_item_t item0,
    input  gspch_pkg::res_item_t item1,
    input  logic                 pop,
    output gspch_pkg::res_item_t head,
    output logic                 not_empty,
    output logic                 room2
);

    gspch_pkg::res_item_t entries_reg [4];
    logic [1:0]           wr_reg, wr_next;
    logic [1:0]           rd_reg, rd_next;
    logic [2:0]           count_reg, count_next;
    logic                 do_pop;

    assign not_empty = (count_reg != 3'd0);
    assign room2     = (count_reg <= 3'd2);
    assign head      = entries_reg[rd_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_next    = wr_reg + {1'b0, push0} + {1'b0, push1};
        rd_next    = rd_reg + {1'b0, do_pop};
        count_next = count_reg + {2'b0, push0} + {2'b0, push1} - {2'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 2'd0;
            rd_reg    <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
            entries_reg[wr_reg] <= item0;
        if (push1)
            entries_reg[wr_reg + 2'd1] <= item1;
    end

endmodule

### sv/gamepad_spi_poll_config_host_unit.sv
// Top level of the gamepad SPI poll and configure host.
// Holds the input register and the configuration registers.
// Depends on gspch_pkg, gspch_core and gspch_res_fifo.

// An item is taken into an input register, worked on by the sequencer once the
// queue has room for two results, and its results, none, one or two, enter a
// four-entry result queue that drives the output port. One item is accepted per
// cycle while the queue has room for two results, so the sustained rate is one
// item per cycle for items that give at most one result and is set by the output
// port, one result per cycle while m_tready is high, when frames end and the next
// one starts. Configuration is written through a plain write port and must only
// change while no command is running.
module gamepad_spi_poll_config_host_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rx_byte [7:0], link_ok [8], small_motor_on [9], large_motor_level [17:10]
    input  logic [23:0] s_tdata,
    // command [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_byte [7:0], done_res [8], success [9], error_code [13:10],
    // buttons_pressed [29:14], right_stick_x [37:30], right_stick_y [45:38],
    // left_stick_x [53:46], left_stick_y [61:54], controller_id [69:62],
    // analog_mode [70]
    output logic [71:0] m_tdata,
    // link_action [1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    gspch_pkg::in_item_t  in_item_reg;
    logic                 in_valid_reg;
    gspch_pkg::cfg_t      cfg_reg;
    gspch_pkg::step_t     step;
    gspch_pkg::res_item_t head;
    logic                 room2;
    logic                 not_empty;
    logic                 fire;
    logic                 s_accept;

    assign fire     = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || room2;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.command           <= s_tuser;
            in_item_reg.rx_byte           <= s_tdata[7:0];
            in_item_reg.link_ok           <= s_tdata[8];
            in_item_reg.small_motor_on    <= s_tdata[9];
            in_item_reg.large_motor_level <= s_tdata[17:10];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.analog_lock_enable <= 1'b0;
            cfg_reg.rumble_enable      <= 1'b0;
            cfg_reg.max_attempts       <= gspch_pkg::MAX_ATTEMPTS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                gspch_pkg::REG_ANALOG_LOCK: cfg_reg.analog_lock_enable <= cfg_data[0];
                gspch_pkg::REG_RUMBLE:      cfg_reg.rumble_enable      <= cfg_data[0];
                gspch_pkg::REG_MAX_ATTEMPT: cfg_reg.max_attempts       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    gspch_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .step  (step)
    );

    gspch_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (fire && step.valid0),
        .push1     (fire && step.valid1),
        .item0     (step.res0),
        .item1     (step.res1),
        .pop       (m_tready),
        .head      (head),
        .not_empty (not_empty),
        .room2     (room2)
    );

    assign m_tvalid = not_empty;
    assign m_tuser  = head.link_action;
    assign m_tdata  = {1'b0, head.analog_mode, head.controller_id, head.left_stick_y,
                       head.left_stick_x, head.right_stick_y, head.right_stick_x,
                       head.buttons_pressed, head.error_code, head.success,
                       head.done_res, head.tx_byte};

endmodule
